### hdl/cpvc_pkg.sv
`default_nettype none
package cpvc_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam int LimW = 21;

  localparam logic [CfgIdxW-1:0] REG_TARGET_X = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_TARGET_Y = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_TARGET_Z = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_CTRL_EN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HLIM = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CLIMB = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DESCENT = 3'd6;

  localparam logic signed [25:0] KP_Q24 = 26'sd8388608;
  localparam logic signed [25:0] KI_XY_Q24 = 26'sd3355443;
  localparam logic signed [25:0] KI_Z_Q24 = 26'sd83886;
  localparam logic signed [33:0] INT_LIMIT = 34'sd964362;
  localparam logic signed [33:0] GRAVITY_Q16 = 34'sd642253;
  localparam logic signed [33:0] THR_XY_MAX = 34'sd131072;
  localparam logic signed [33:0] THR_Z_MIN = 34'sd589824;
  localparam logic signed [33:0] THR_Z_MAX = 34'sd655360;

  // datapath commands from the controller
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_SQ_X, OP_SQ_Y, OP_SQRT_INIT, OP_SQRT_STEP,
    OP_DIV_INIT, OP_DIV_STEP, OP_DIV_DONE, OP_ZCLAMP,
    OP_AX_MUL1, OP_AX_MUL2, OP_AX_DONE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       div_sel;
  } cmd_t;

  typedef struct packed {
    logic over_limit;
  } sts_t;

endpackage
`default_nettype wire

### hdl/cpvc_ctrl.sv
`default_nettype none
module cpvc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          out_free,
  input  wire cpvc_pkg::sts_t sts,
  output cpvc_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);
  import cpvc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SQI, S_SQS, S_CHK, S_DI, S_DS, S_DD,
    S_ZC, S_M1, S_M2, S_AD, S_OUT
  } state_t;

  state_t     state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic       dsel_r, dsel_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ax_nxt = ax_r;
    dsel_nxt = dsel_r;
    cmd = '{op: OP_NONE, axis: ax_r, div_sel: dsel_r};
    done = 1'b0;
    case (state_r)
      S_IDLE: if (start) begin
        cmd.op = OP_LOAD;
        state_nxt = S_SQX;
      end
      S_SQX: begin
        cmd.op = OP_SQ_X;
        state_nxt = S_SQY;
      end
      S_SQY: begin
        cmd.op = OP_SQ_Y;
        state_nxt = S_SQI;
      end
      S_SQI: begin
        cmd.op = OP_SQRT_INIT;
        cnt_nxt = 6'd31;
        state_nxt = S_SQS;
      end
      S_SQS: begin
        cmd.op = OP_SQRT_STEP;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_nxt = S_CHK;
      end
      S_CHK: begin
        dsel_nxt = 1'b0;
        state_nxt = sts.over_limit ? S_DI : S_ZC;
      end
      S_DI: begin
        cmd.op = OP_DIV_INIT;
        cnt_nxt = 6'd52;
        state_nxt = S_DS;
      end
      S_DS: begin
        cmd.op = OP_DIV_STEP;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == 6'd0) state_nxt = S_DD;
      end
      S_DD: begin
        cmd.op = OP_DIV_DONE;
        dsel_nxt = 1'b1;
        state_nxt = dsel_r ? S_ZC : S_DI;
      end
      S_ZC: begin
        cmd.op = OP_ZCLAMP;
        ax_nxt = 2'd0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd.op = OP_AX_MUL1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op = OP_AX_MUL2;
        state_nxt = S_AD;
      end
      S_AD: begin
        cmd.op = OP_AX_DONE;
        ax_nxt = (ax_r == 2'd2) ? 2'd0 : ax_r + 2'd1;
        state_nxt = (ax_r == 2'd2) ? S_OUT : S_M1;
      end
      S_OUT: if (out_free) begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      ax_r <= '0;
      dsel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ax_r <= ax_nxt;
      dsel_r <= dsel_nxt;
    end
  end
endmodule
`default_nettype wire

### hdl/cpvc_dp.sv
`default_nettype none
module cpvc_dp (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire cpvc_pkg::cmd_t       cmd,
  output cpvc_pkg::sts_t            sts,
  input  wire logic [3*32-1:0]      pos,
  input  wire logic [3*32-1:0]      vel,
  input  wire logic [15:0]          dt,
  input  wire logic [3*32-1:0]      tgt,
  input  wire logic                 ctrl_en,
  input  wire logic [cpvc_pkg::LimW-1:0] hlim,
  input  wire logic [cpvc_pkg::LimW-1:0] climb,
  input  wire logic [cpvc_pkg::LimW-1:0] descent,
  output logic signed [18:0]        thr_x,
  output logic signed [18:0]        thr_y,
  output logic [19:0]               thr_z
);
  import cpvc_pkg::*;

  logic signed [31:0] sp_r [3];
  logic signed [31:0] integ_r [3];
  logic signed [31:0] vel_r [3];
  logic [15:0]        dt_r;
  logic [63:0]        sum_r;
  logic [63:0]        rem_r;
  logic [31:0]        root_r;
  logic [52:0]        num_r;
  logic [52:0]        q_r;
  logic [32:0]        drem_r;
  logic               neg_r;
  logic signed [32:0] e_r;
  logic signed [48:0] t_r;
  logic signed [57:0] pt_r;
  logic signed [33:0] thr_r [3];

  logic signed [32:0] d_w [3];
  logic signed [31:0] sp_sel;
  logic [31:0]        mag;
  logic [63:0]        trial;
  logic [33:0]        dtrial;
  logic [33:0]        dshift;
  logic signed [33:0] rnd_t;
  logic signed [25:0] ki;
  logic signed [74:0] inc_p;
  logic signed [33:0] inc;
  logic signed [33:0] acc_sum;
  logic signed [33:0] acc;
  logic signed [33:0] pterm;
  logic signed [31:0] q32;
  logic [1:0]         ax;

  assign ax = cmd.axis;
  assign sp_sel = sp_r[{1'b0, cmd.div_sel}];
  assign mag = sp_sel[31] ? 32'(-sp_sel) : 32'(sp_sel);
  assign sts.over_limit = ({32'd0, root_r} > {43'd0, hlim});
  assign trial = {rem_r[61:0], sum_r[63:62]} - {30'd0, root_r, 2'b01};
  assign dshift = {drem_r, num_r[52]};
  assign dtrial = dshift - {2'b0, root_r};
  assign q32 = neg_r ? -$signed(q_r[31:0]) : $signed(q_r[31:0]);
  assign ki = (ax == 2'd2) ? KI_Z_Q24 : KI_XY_Q24;
  assign rnd_t = 34'((t_r + 49'sd32768) >>> 16);
  assign inc_p = rnd_t * ki;
  assign inc = 34'((inc_p + 75'sd8388608) >>> 24);
  assign pterm = 34'((pt_r + 58'sd8388608) >>> 24);
  assign acc_sum = $signed({{2{integ_r[ax][31]}}, integ_r[ax]}) + inc;
  assign acc = (acc_sum > INT_LIMIT) ? INT_LIMIT :
               (acc_sum < -INT_LIMIT) ? -INT_LIMIT : acc_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_w[i] = {tgt[i*32+31], tgt[i*32 +: 32]} - {pos[i*32+31], pos[i*32 +: 32]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sp_r[i] <= '0;
        integ_r[i] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            vel_r[i] <= vel[i*32 +: 32];
            if (ctrl_en) begin
              if (d_w[i] > 33'sd2147483647) sp_r[i] <= 32'h7fffffff;
              else if (d_w[i] < -33'sd2147483648) sp_r[i] <= 32'h80000000;
              else sp_r[i] <= d_w[i][31:0];
            end
          end
          dt_r <= dt;
        end
        OP_SQ_X: sum_r <= 64'(sp_r[0] * sp_r[0]);
        OP_SQ_Y: sum_r <= sum_r + 64'(sp_r[1] * sp_r[1]);
        OP_SQRT_INIT: begin
          rem_r <= '0;
          root_r <= '0;
        end
        OP_SQRT_STEP: begin
          sum_r <= {sum_r[61:0], 2'b00};
          if (!trial[63] && ({rem_r[61:0], sum_r[63:62]} >= {30'd0, root_r, 2'b01})) begin
            rem_r <= trial;
            root_r <= {root_r[30:0], 1'b1};
          end else begin
            rem_r <= {rem_r[61:0], sum_r[63:62]};
            root_r <= {root_r[30:0], 1'b0};
          end
        end
        OP_DIV_INIT: begin
          num_r <= 53'(mag * hlim);
          neg_r <= sp_sel[31];
          drem_r <= '0;
          q_r <= '0;
        end
        OP_DIV_STEP: begin
          num_r <= {num_r[51:0], 1'b0};
          if (dshift >= {2'b0, root_r}) begin
            drem_r <= dtrial[32:0];
            q_r <= {q_r[51:0], 1'b1};
          end else begin
            drem_r <= dshift[32:0];
            q_r <= {q_r[51:0], 1'b0};
          end
        end
        OP_DIV_DONE: sp_r[{1'b0, cmd.div_sel}] <= q32;
        OP_ZCLAMP: begin
          if (sp_r[2] < -$signed({11'd0, climb})) sp_r[2] <= -$signed({11'd0, climb});
          else if (sp_r[2] > $signed({11'd0, descent})) sp_r[2] <= $signed({11'd0, descent});
        end
        OP_AX_MUL1: begin
          e_r <= {sp_r[ax][31], sp_r[ax]} - {vel_r[ax][31], vel_r[ax]};
        end
        OP_AX_MUL2: begin
          t_r <= e_r * $signed({1'b0, dt_r});
          pt_r <= e_r * KP_Q24;
        end
        OP_AX_DONE: begin
          integ_r[ax] <= acc[31:0];
          if (ax == 2'd2) begin
            thr_r[2] <= (pterm + acc + GRAVITY_Q16 < THR_Z_MIN) ? THR_Z_MIN :
                        (pterm + acc + GRAVITY_Q16 > THR_Z_MAX) ? THR_Z_MAX :
                        pterm + acc + GRAVITY_Q16;
          end else begin
            thr_r[ax] <= (pterm + acc < -THR_XY_MAX) ? -THR_XY_MAX :
                         (pterm + acc > THR_XY_MAX) ? THR_XY_MAX : pterm + acc;
          end
        end
        default: ;
      endcase
    end
  end

  assign thr_x = thr_r[0][18:0];
  assign thr_y = thr_r[1][18:0];
  assign thr_z = thr_r[2][19:0];
endmodule
`default_nettype wire

### hdl/cascade_position_velocity_controller_top.sv
// cascaded position / velocity controller, one control tick per item
// in_*: axis-style input channel, tdata holds pos_x..z, vel_x..z, time_step
// out_*: result channel, tdata holds thrust_x, thrust_y, thrust_z
// cfg_*: write port, index 0..6 = targets, enable, speed limits
// an item passes from acceptance to out_tvalid through a 32-step square
// root that gives the horizontal setpoint length, then three passes of the
// shared PI unit; when the length exceeds the limit two restoring divides
// that scale the x and y setpoints come before the PI passes
// one item is processed at a time; in_tready is high while idle, so a new
// item is accepted only once the controller is idle again
// the result sits in an output register until taken; a new item may be
// accepted meanwhile, and it waits in its last step until the register
// is free again
// reset clears setpoint and integrator state, sets limits to defaults
// write configuration only while idle
`default_nettype none
module cascade_position_velocity_controller_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [207:0] in_tdata,  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, time_step
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [63:0]       out_tdata, // thrust_x, thrust_y, thrust_z
  input  wire logic         cfg_we,
  input  wire logic [cpvc_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [cpvc_pkg::CfgDataW-1:0] cfg_data
);
  import cpvc_pkg::*;

  logic [95:0]     tgt_r;
  logic            en_r;
  logic [LimW-1:0] hlim_r, climb_r, desc_r;
  logic            ov_r;
  logic [57:0]     res_r;
  cmd_t            cmd;
  sts_t            sts;
  logic            busy, done, start;
  logic signed [18:0] tx, ty;
  logic [19:0]     tz;

  assign in_tready = !busy;
  assign start = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r <= '0;
      en_r <= 1'b0;
      hlim_r <= 21'd131072;
      climb_r <= 21'd131072;
      desc_r <= 21'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_X: tgt_r[31:0] <= cfg_data;
        REG_TARGET_Y: tgt_r[63:32] <= cfg_data;
        REG_TARGET_Z: tgt_r[95:64] <= cfg_data;
        REG_CTRL_EN: en_r <= cfg_data[0];
        REG_HLIM: hlim_r <= cfg_data[LimW-1:0];
        REG_CLIMB: climb_r <= cfg_data[LimW-1:0];
        REG_DESCENT: desc_r <= cfg_data[LimW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (done) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) res_r <= {tz, ty, tx};
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, res_r};

  cpvc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .out_free(!ov_r),
    .sts(sts), .cmd(cmd), .busy(busy), .done(done)
  );

  cpvc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .pos(in_tdata[95:0]), .vel(in_tdata[191:96]), .dt(in_tdata[207:192]),
    .tgt(tgt_r), .ctrl_en(en_r), .hlim(hlim_r), .climb(climb_r), .descent(desc_r),
    .thr_x(tx), .thr_y(ty), .thr_z(tz)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !in_tready) else $error("accept while busy");
  a_done_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_tvalid) else $error("result lost");
  a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !out_tvalid) else $error("result overwritten");
endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import cpvc_pkg::*;

  typedef struct {
    logic signed [31:0] pos [3];
    logic signed [31:0] vel [3];
    logic [15:0]        dt;
  } tick_t;

  typedef struct {
    logic signed [18:0] tx;
    logic signed [18:0] ty;
    logic [19:0]        tz;
  } thrust_t;

  typedef struct {
    bit                    is_cfg;
    logic [CfgIdxW-1:0]    idx;
    logic [CfgDataW-1:0]   val;
    tick_t                 tick;
    bit                    has_exp;
    thrust_t               exp;
  } step_t;

  localparam int IdleLatency = 160;
  localparam int StallLimit = 20000;
  localparam int HoldCycles = 500;
  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [207:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  always #1 clk = ~clk;

  cascade_position_velocity_controller_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // controller copy
  logic signed [31:0] tgt [3];
  logic ctrl_en;
  logic [20:0] hlim, climb, descent;
  logic signed [31:0] vel_sp [3];
  logic signed [31:0] vel_int [3];

  thrust_t thrust_q [$];
  step_t steps [$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int mode = 0;
  bit hold_req = 1'b0;
  int stall = 0;

  function automatic longint rnd_shift(longint x, int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned rem, res, b;
    rem = v;
    res = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic thrust_t predict_thrust(tick_t t);
    longint sx, sy, lim, n, e, ti, inc, acc, ki;
    longint thr [3];
    longint unsigned len;
    thrust_t r;
    if (ctrl_en) begin
      for (int i = 0; i < 3; i++)
        vel_sp[i] = 32'(clampl(longint'(tgt[i]) - longint'(t.pos[i]),
                               -64'sd2147483648, 64'sd2147483647));
    end
    sx = longint'(vel_sp[0]);
    sy = longint'(vel_sp[1]);
    len = int_sqrt(longint'(sx * sx) + longint'(sy * sy));
    if (len > longint'(hlim)) begin
      lim = longint'({1'b0, hlim});
      n = longint'(len);
      vel_sp[0] = 32'((sx * lim) / n);
      vel_sp[1] = 32'((sy * lim) / n);
    end
    vel_sp[2] = 32'(clampl(vel_sp[2], -longint'({1'b0, climb}),
                           longint'({1'b0, descent})));
    for (int i = 0; i < 3; i++) begin
      ki = (i == 2) ? longint'(KI_Z_Q24) : longint'(KI_XY_Q24);
      e = longint'(vel_sp[i]) - longint'(t.vel[i]);
      ti = rnd_shift(e * longint'({1'b0, t.dt}), 16);
      inc = rnd_shift(ti * ki, 24);
      acc = clampl(longint'(vel_int[i]) + inc, -longint'(INT_LIMIT), longint'(INT_LIMIT));
      vel_int[i] = 32'(acc);
      thr[i] = rnd_shift(e * longint'(KP_Q24), 24) + acc;
    end
    thr[2] = thr[2] + longint'(GRAVITY_Q16);
    r.tx = 19'(clampl(thr[0], -longint'(THR_XY_MAX), longint'(THR_XY_MAX)));
    r.ty = 19'(clampl(thr[1], -longint'(THR_XY_MAX), longint'(THR_XY_MAX)));
    r.tz = 20'(clampl(thr[2], longint'(THR_Z_MIN), longint'(THR_Z_MAX)));
    return r;
  endfunction

  function automatic tick_t mk_tick(logic [31:0] p0, logic [31:0] p1, logic [31:0] p2,
                                    logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                                    logic [15:0] dt);
    tick_t t;
    t.pos[0] = p0; t.pos[1] = p1; t.pos[2] = p2;
    t.vel[0] = v0; t.vel[1] = v1; t.vel[2] = v2;
    t.dt = dt;
    return t;
  endfunction

  function automatic step_t item_step(tick_t t, bit has_exp, thrust_t exp);
    step_t s;
    s = '{default: '0};
    s.tick = t;
    s.has_exp = has_exp;
    s.exp = exp;
    return s;
  endfunction

  function automatic step_t cfg_step(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    step_t s;
    s = '{default: '0};
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic logic [31:0] rand_near(logic signed [31:0] c, int span);
    return c + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int k;
    k = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (k < 7) begin
        t.pos[i] = rand_near(tgt[i], 6 << 16);
        t.vel[i] = rand_near(0, 5 << 16);
      end else begin
        t.pos[i] = $urandom;
        t.vel[i] = $urandom;
      end
    end
    case ($urandom_range(0, 5))
      0: t.dt = 16'd0;
      1: t.dt = 16'hffff;
      2: t.dt = 16'($urandom);
      default: t.dt = 16'($urandom_range(1, 1000));
    endcase
    return t;
  endfunction

  task automatic wait_idle();
    while (thrust_q.size() != 0) @(posedge clk);
    repeat (IdleLatency) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_TARGET_X: tgt[0] = val;
      REG_TARGET_Y: tgt[1] = val;
      REG_TARGET_Z: tgt[2] = val;
      REG_CTRL_EN: ctrl_en = val[0];
      REG_HLIM: hlim = val[20:0];
      REG_CLIMB: climb = val[20:0];
      REG_DESCENT: descent = val[20:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_tick(tick_t t, bit has_exp, thrust_t exp);
    thrust_t p;
    @(negedge clk);
    while ((mode == 0 && $urandom_range(0, 99) < 23) ||
           (mode == 1 && $urandom_range(0, 99) < 51)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {t.dt, t.vel[2], t.vel[1], t.vel[0], t.pos[2], t.pos[1], t.pos[0]};
    do @(posedge clk); while (!in_tready);
    p = predict_thrust(t);
    thrust_q.push_back(has_exp ? exp : p);
    n_items++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // receiver
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end
      out_tready <= !((mode == 0 && $urandom_range(0, 99) < 51) ||
                      (mode == 1 && $urandom_range(0, 99) < 23));
    end
  end

  // result checker
  always @(posedge clk) begin
    thrust_t e;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (thrust_q.size() == 0) begin
        $error("unexpected result %h", out_tdata);
        errors++;
      end else begin
        e = thrust_q.pop_front();
        if (out_tdata[18:0] !== e.tx) begin
          $error("thrust_x exp %0d got %0d", e.tx, $signed(out_tdata[18:0]));
          errors++;
        end
        if (out_tdata[37:19] !== e.ty) begin
          $error("thrust_y exp %0d got %0d", e.ty, $signed(out_tdata[37:19]));
          errors++;
        end
        if (out_tdata[57:38] !== e.tz) begin
          $error("thrust_z exp %0d got %0d", e.tz, out_tdata[57:38]);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      stall <= 0;
    else
      stall <= stall + 1;
    if (stall > StallLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    thrust_t z0, vmax, vmin, none;
    tick_t t;
    step_t s;
    logic [31:0] lims [4];
    lims = '{32'd0, 32'd1310720, 32'h1fffff, 32'd65536};
    none = '{default: '0};
    z0 = '{tx: 19'sd0, ty: 19'sd0, tz: 20'd642253};
    vmax = '{tx: -19'sd131072, ty: -19'sd131072, tz: 20'd589824};
    vmin = '{tx: 19'sd131072, ty: 19'sd131072, tz: 20'd655360};
    tgt = '{0, 0, 0};
    ctrl_en = 1'b0;
    hlim = 21'd131072;
    climb = 21'd131072;
    descent = 21'd65536;
    vel_sp = '{0, 0, 0};
    vel_int = '{0, 0, 0};

    steps.push_back(item_step(mk_tick(0, 0, 0, 0, 0, 0, 16'd0), 1'b1, z0));
    steps.push_back(item_step(mk_tick(0, 0, 0, 32'h7fffffff, 32'h7fffffff,
                                      32'h7fffffff, 16'd0), 1'b1, vmax));
    steps.push_back(item_step(mk_tick(0, 0, 0, 32'h80000000, 32'h80000000,
                                      32'h80000000, 16'd0), 1'b1, vmin));
    steps.push_back(item_step(mk_tick(0, 0, 0, 32'h80000000, 32'h7fffffff,
                                      32'h80000000, 16'hffff), 1'b0, none));
    steps.push_back(cfg_step(RegUnused, 32'hffffffff));
    steps.push_back(cfg_step(REG_TARGET_X, 32'h7fffffff));
    steps.push_back(cfg_step(REG_TARGET_Y, 32'h80000000));
    steps.push_back(cfg_step(REG_TARGET_Z, 32'h7fffffff));
    steps.push_back(cfg_step(REG_CTRL_EN, 32'd1));
    steps.push_back(cfg_step(REG_HLIM, 32'd0));
    steps.push_back(item_step(mk_tick(32'h80000000, 32'h7fffffff, 32'h80000000,
                                      0, 0, 0, 16'h8000), 1'b0, none));
    steps.push_back(cfg_step(REG_HLIM, 32'd1310720));
    steps.push_back(cfg_step(REG_CLIMB, 32'd1310720));
    steps.push_back(cfg_step(REG_DESCENT, 32'd0));
    steps.push_back(item_step(mk_tick(0, 0, 32'h7fffffff, 32'h00010000,
                                      32'hffff0000, 0, 16'h0001), 1'b0, none));
    steps.push_back(cfg_step(REG_HLIM, 32'h1fffff));
    steps.push_back(cfg_step(REG_DESCENT, 32'h1fffff));
    steps.push_back(item_step(mk_tick(32'h7ffe0000, 32'h80030000, 32'h7ff00000,
                                      0, 0, 0, 16'd655), 1'b0, none));
    steps.push_back(cfg_step(REG_CTRL_EN, 32'd0));
    steps.push_back(cfg_step(REG_HLIM, 32'd65536));
    steps.push_back(item_step(mk_tick(0, 0, 0, 0, 0, 0, 16'd655), 1'b0, none));
    steps.push_back(cfg_step(REG_CTRL_EN, 32'd1));
    steps.push_back(item_step(mk_tick(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      32'h80000000, 32'h80000000, 32'h80000000,
                                      16'hffff), 1'b0, none));
    steps.push_back(item_step(mk_tick(32'h80000000, 32'h80000000, 32'h80000000,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      16'hffff), 1'b0, none));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      s = steps[i];
      if (s.is_cfg) begin
        end_burst();
        write_reg(s.idx, s.val);
      end else begin
        send_tick(s.tick, s.has_exp, s.exp);
      end
    end
    end_burst();

    for (int ph = 0; ph < 14; ph++) begin
      mode = ph * 3 / 14;
      write_reg(REG_TARGET_X, $urandom);
      write_reg(REG_TARGET_Y, $urandom);
      write_reg(REG_TARGET_Z, (ph % 4 == 0) ? $urandom : rand_near(0, 50 << 16));
      write_reg(REG_CTRL_EN, 32'(ph % 5 != 4));
      write_reg(REG_HLIM, (ph % 3 == 0) ? lims[$urandom_range(0, 3)] : $urandom);
      write_reg(REG_CLIMB, (ph % 4 == 1) ? lims[$urandom_range(0, 3)] : $urandom);
      write_reg(REG_DESCENT, (ph % 4 == 2) ? lims[$urandom_range(0, 3)] : $urandom);
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < 50; k++) begin
        t = rand_tick();
        send_tick(t, 1'b0, none);
      end
      end_burst();
    end

    while (thrust_q.size() != 0) @(posedge clk);
    repeat (IdleLatency) @(posedge clk);
    $display("tb: %0d ticks sent, %0d thrust results checked, %0d register writes",
             n_items, n_results, n_cfg);
    $display("tb: covered limit extremes, disabled control, saturation and stalls");
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
